// ----- src/dshot_frame_transmitter_defines.svh -----
// Assertion helpers for the DShot frame transmitter.
// Each macro expects signals clk and rst in the scope where it is used.
`ifndef DSHOT_FRAME_TRANSMITTER_DEFINES_SVH
`define DSHOT_FRAME_TRANSMITTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define DFT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("dshot frame transmitter: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define DFT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("dshot frame transmitter: next-cycle check failed");

`endif

// ----- src/dft_pkg.sv -----
// ----------------------------------------------------------------------------
// dft_pkg
// Shared types, constants and the frame encoder of the DShot transmitter.
// ----------------------------------------------------------------------------
package dft_pkg;

  localparam int REG_W        = 12;
  localparam int THROTTLE_W   = 11;
  localparam int FRAME_BITS   = 16;
  localparam int TICK_WIDTH   = 12;
  localparam int QUEUE_DEPTH  = 2;    // power of two
  localparam int CFG_INDEX_W  = 2;
  localparam int LOW_THRESH   = 48;   // doubled values below this get bit 0 set

  localparam logic [REG_W-1:0] BIT_TICKS_RST  = REG_W'(34);
  localparam logic [REG_W-1:0] ONE_HIGH_RST   = REG_W'(26);
  localparam logic [REG_W-1:0] ZERO_HIGH_RST  = REG_W'(13);

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_BIT_TICKS  = 2'd0,
    REG_ONE_HIGH   = 2'd1,
    REG_ZERO_HIGH  = 2'd2
  } reg_index_t;

  typedef struct packed {
    logic                   we;
    logic [CFG_INDEX_W-1:0] index;
    logic [REG_W-1:0]       data;
  } cfg_write_t;

  // One classified tick as it sits in the queue.
  typedef struct packed {
    logic                  start_req;
    logic [FRAME_BITS-1:0] frame;
  } tick_entry_t;

  // Doubled throttle, low flag, then XOR of the three nibbles.
  function automatic logic [FRAME_BITS-1:0] make_frame(input logic [THROTTLE_W-1:0] thr);
    logic [THROTTLE_W:0] v;
    logic [3:0]          sum;
    v = {thr, 1'b0};
    if (v < (THROTTLE_W+1)'(LOW_THRESH)) v[0] = 1'b1;
    sum = v[3:0] ^ v[7:4] ^ v[11:8];
    return {v, sum};
  endfunction

endpackage

// ----- src/dft_interfaces.sv -----
// ----------------------------------------------------------------------------
// dft_interfaces
// Valid/ready channels for tick words and result words.
// ----------------------------------------------------------------------------
interface dft_tick_if import dft_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  start_req;
  logic [THROTTLE_W-1:0] throttle;

  modport source (output valid, start_req, throttle, input ready);
  modport sink   (input valid, start_req, throttle, output ready);
  modport mon    (input valid, ready, start_req, throttle);
endinterface

interface dft_result_if import dft_pkg::*; ();
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;
  logic frame_done;

  modport source (output valid, line_level, busy_res, accepted, frame_done, input ready);
  modport sink   (input valid, line_level, busy_res, accepted, frame_done, output ready);
  modport mon    (input valid, ready, line_level, busy_res, accepted, frame_done);
endinterface

// ----- src/dshot_frame_transmitter.sv -----
// ----------------------------------------------------------------------------
// dshot_frame_transmitter
// One-channel DShot frame encoder and pulse-width bit transmitter.
// ----------------------------------------------------------------------------
// Usage:
//   ticks   : one word per waveform tick; start_req with throttle asks for a
//             new frame, taken only when no frame is in flight.
//   results : one word per tick word: line_level, busy_res, accepted and
//             frame_done for that tick.
//   cfg_*   : write-only port for bit_ticks, one_high_ticks, zero_high_ticks;
//             write only while idle. Unknown indexes are dropped.
// Throughput: one tick word per cycle while the receiver keeps taking results.
// Path: a taken tick word is written into the queue, then the timing engine
//   fills the result register from the queue head.
// Receiver stall: the result register holds; the two-entry queue soaks up
//   incoming words, and ticks.ready drops once it is full. Waveform timing
//   counts tick words, not clock cycles, so stalls never distort it.
// Reset: queue empty, no result pending, transmitter idle, registers back to
//   34 / 26 / 13 ticks.
// ----------------------------------------------------------------------------
module dshot_frame_transmitter import dft_pkg::*; #(
  parameter int TICK_W = TICK_WIDTH
) (
  input  logic                   clk,
  input  logic                   rst,
  dft_tick_if.sink               ticks,
  dft_result_if.source           results,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data
);

  logic        push_valid;
  logic        push_ready;
  tick_entry_t push_entry;
  logic        pop_valid;
  logic        pop_ready;
  tick_entry_t pop_entry;
  cfg_write_t  cfg;

  assign cfg.we    = cfg_we;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  // front: accept and encode
  dft_front u_front (
    .ticks      (ticks),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  // decoupling queue
  dft_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  // back: bit timing and result register
  dft_back #(.TICK_W(TICK_W)) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .results   (results)
  );

endmodule

// ----- src/dft_front.sv -----
// ----------------------------------------------------------------------------
// dft_front
// Takes tick words and encodes the throttle into a frame for the queue.
// ----------------------------------------------------------------------------
module dft_front import dft_pkg::*; (
  dft_tick_if.sink      ticks,
  output logic          push_valid,
  input  logic          push_ready,
  output tick_entry_t   push_entry
);

  assign ticks.ready          = push_ready;
  assign push_valid           = ticks.valid;
  assign push_entry.start_req = ticks.start_req;
  // frame is only used when the back end is idle and start_req is set
  assign push_entry.frame     = make_frame(ticks.throttle);

endmodule

// ----- src/dft_queue.sv -----
// ----------------------------------------------------------------------------
// dft_queue
// Small FIFO between the encoder front and the waveform back end.
// ----------------------------------------------------------------------------
module dft_queue import dft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push_valid,
  output logic        push_ready,
  input  tick_entry_t push_entry,
  output logic        pop_valid,
  input  logic        pop_ready,
  output tick_entry_t pop_entry
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  tick_entry_t      mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign push_ready = (count != CNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_entry  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + PTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- src/dft_back.sv -----
// ----------------------------------------------------------------------------
// dft_back
// Bit timing engine: runs one tick per queue entry, registers each result.
// ----------------------------------------------------------------------------
module dft_back import dft_pkg::*; #(
  parameter int TICK_W = TICK_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_write_t    cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  tick_entry_t   pop_entry,
  dft_result_if.source  results
);

  localparam int CMP_W  = ((TICK_W > REG_W) ? TICK_W : REG_W) + 1;
  localparam int LEFT_W = $clog2(FRAME_BITS + 1);

  logic [REG_W-1:0]      bit_ticks;
  logic [REG_W-1:0]      one_high_ticks;
  logic [REG_W-1:0]      zero_high_ticks;

  logic                  sending;
  logic [FRAME_BITS-1:0] frame_shift;
  logic [LEFT_W-1:0]     bits_left;
  logic [TICK_W-1:0]     tick_count;

  logic                  sending_next;
  logic [FRAME_BITS-1:0] frame_shift_next;
  logic [LEFT_W-1:0]     bits_left_next;
  logic [TICK_W-1:0]     tick_count_next;

  logic                  step;
  logic                  start_now;
  logic                  active;
  logic [FRAME_BITS-1:0] cur_shift;
  logic [LEFT_W-1:0]     cur_left;
  logic [TICK_W-1:0]     cur_tick;
  logic [REG_W-1:0]      high_ticks;
  logic                  period_end;
  logic                  line_d;
  logic                  done_d;

  // config registers; the user must write them only while idle, not enforced here
  always_ff @(posedge clk) begin
    if (rst) begin
      bit_ticks       <= BIT_TICKS_RST;
      one_high_ticks  <= ONE_HIGH_RST;
      zero_high_ticks <= ZERO_HIGH_RST;
    end else if (cfg.we) begin
      unique case (cfg.index)
        REG_BIT_TICKS: bit_ticks       <= cfg.data;
        REG_ONE_HIGH:  one_high_ticks  <= cfg.data;
        REG_ZERO_HIGH: zero_high_ticks <= cfg.data;
        default:       ;
      endcase
    end
  end

  // advance when the result register is free or being drained
  assign step      = pop_valid && (!results.valid || results.ready);
  assign pop_ready = step;

  always_comb begin
    start_now  = !sending && pop_entry.start_req;
    active     = sending || start_now;
    cur_shift  = start_now ? pop_entry.frame : frame_shift;
    cur_left   = start_now ? LEFT_W'(FRAME_BITS) : bits_left;
    cur_tick   = start_now ? '0 : tick_count;
    high_ticks = cur_shift[FRAME_BITS-1] ? one_high_ticks : zero_high_ticks;
    line_d     = active && (CMP_W'(cur_tick) < CMP_W'(high_ticks));
    period_end = (CMP_W'(cur_tick) + CMP_W'(1) >= CMP_W'(bit_ticks)) || (&cur_tick);

    sending_next     = sending;
    frame_shift_next = frame_shift;
    bits_left_next   = bits_left;
    tick_count_next  = tick_count;
    done_d           = 1'b0;
    if (active) begin
      if (period_end) begin
        tick_count_next  = '0;
        frame_shift_next = {cur_shift[FRAME_BITS-2:0], 1'b0};
        bits_left_next   = cur_left - LEFT_W'(1);
        done_d           = (cur_left == LEFT_W'(1));
        sending_next     = !done_d;
      end else begin
        tick_count_next  = cur_tick + TICK_W'(1);
        frame_shift_next = cur_shift;
        bits_left_next   = cur_left;
        sending_next     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending     <= 1'b0;
      frame_shift <= '0;
      bits_left   <= '0;
      tick_count  <= '0;
    end else if (step) begin
      sending     <= sending_next;
      frame_shift <= frame_shift_next;
      bits_left   <= bits_left_next;
      tick_count  <= tick_count_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (step) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      results.line_level <= line_d;
      results.busy_res   <= active;
      results.accepted   <= start_now;
      results.frame_done <= done_d;
    end
  end

endmodule

// ----- src/dft_checker.sv -----
// ----------------------------------------------------------------------------
// dft_checker
// Port-level checks on the result channel of the DShot transmitter.
// ----------------------------------------------------------------------------
`include "dshot_frame_transmitter_defines.svh"

module dft_checker (
  input logic clk,
  input logic rst,
  input logic valid,
  input logic ready,
  input logic line_level,
  input logic busy_res,
  input logic accepted,
  input logic frame_done
);

  `DFT_ASSERT_NOW(a_done_busy, valid && frame_done, busy_res)
  `DFT_ASSERT_NOW(a_acc_busy, valid && accepted, busy_res)
  `DFT_ASSERT_NOW(a_idle_low, valid && !busy_res, !line_level)
  `DFT_ASSERT_NEXT(a_hold, valid && !ready, valid && $stable(busy_res))

endmodule

bind dshot_frame_transmitter dft_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .valid      (results.valid),
  .ready      (results.ready),
  .line_level (results.line_level),
  .busy_res   (results.busy_res),
  .accepted   (results.accepted),
  .frame_done (results.frame_done)
);

// ----- bench/dshot_waveform_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// dshot_waveform_checker
// Watches the tick and result channels and the register port of the DShot
// transmitter, predicts the pin word for every accepted tick word, and
// compares each accepted result word against the oldest prediction.
// ----------------------------------------------------------------------------
module dshot_waveform_checker import dft_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  dft_tick_if.mon                ticks,
  dft_result_if.mon              results,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]       cfg_data,
  output int                     errors,
  output int                     pending,
  output logic                   tx_active,
  output int                     words_checked,
  output int                     frames_done
);

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } pin_word_t;

  localparam logic [TICK_WIDTH-1:0] TICK_TOP  = '1;
  localparam int                    PRINT_CAP = 100;

  // register mirror
  logic [REG_W-1:0]      period_ticks;
  logic [REG_W-1:0]      one_ticks;
  logic [REG_W-1:0]      zero_ticks;
  // transmitter mirror
  logic [FRAME_BITS-1:0] frame_sr;
  logic [4:0]            bits_to_go;
  logic [TICK_WIDTH-1:0] tick_pos;
  logic                  in_frame;

  pin_word_t expected_pins[$];
  int        err_count  = 0;
  int        word_count = 0;
  int        done_count = 0;

  function automatic logic [FRAME_BITS-1:0] encode_frame(input logic [THROTTLE_W-1:0] thr);
    logic [THROTTLE_W:0] value;
    logic [3:0]          crc;
    value = {thr, 1'b0};
    if (value < LOW_THRESH) value[0] = 1'b1;
    crc = value[11:8] ^ value[7:4] ^ value[3:0];
    return {value, crc};
  endfunction

  // One tick of the waveform: returns the pin word and moves the mirror on.
  function automatic pin_word_t advance_waveform(input logic start,
                                                 input logic [THROTTLE_W-1:0] thr);
    pin_word_t        w;
    logic [REG_W-1:0] high;
    w = '0;
    if (!in_frame && start) begin
      frame_sr   = encode_frame(thr);
      bits_to_go = 5'(FRAME_BITS);
      tick_pos   = '0;
      in_frame   = 1'b1;
      w.accepted = 1'b1;
    end
    if (in_frame) begin
      high         = frame_sr[FRAME_BITS-1] ? one_ticks : zero_ticks;
      w.busy_res   = 1'b1;
      w.line_level = (tick_pos < high);
      if (int'(tick_pos) + 1 >= int'(period_ticks) || tick_pos == TICK_TOP) begin
        tick_pos   = '0;
        frame_sr   = frame_sr << 1;
        bits_to_go = bits_to_go - 5'd1;
        if (bits_to_go == 5'd0) begin
          in_frame     = 1'b0;
          w.frame_done = 1'b1;
        end
      end else begin
        tick_pos = tick_pos + 1'b1;
      end
    end
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    if (err_count <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, msg);
    if (err_count == PRINT_CAP) $display("[%0t] further mismatches counted only", $time);
  endtask

  always @(posedge clk) begin : watch
    pin_word_t want;
    pin_word_t got;
    if (rst) begin
      period_ticks = BIT_TICKS_RST;
      one_ticks    = ONE_HIGH_RST;
      zero_ticks   = ZERO_HIGH_RST;
      frame_sr     = '0;
      bits_to_go   = '0;
      tick_pos     = '0;
      in_frame     = 1'b0;
      expected_pins.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BIT_TICKS: period_ticks = cfg_data;
          REG_ONE_HIGH:  one_ticks    = cfg_data;
          REG_ZERO_HIGH: zero_ticks   = cfg_data;
          default: ;
        endcase
      end
      if (results.valid && results.ready) begin
        got = '{results.line_level, results.busy_res, results.accepted, results.frame_done};
        if (expected_pins.size() == 0) begin
          report_mismatch($sformatf("result word %b with no tick word outstanding", got));
        end else begin
          want = expected_pins.pop_front();
          if (got.line_level !== want.line_level)
            report_mismatch($sformatf("word %0d line_level got %b expected %b",
                                      word_count, got.line_level, want.line_level));
          if (got.busy_res !== want.busy_res)
            report_mismatch($sformatf("word %0d busy_res got %b expected %b",
                                      word_count, got.busy_res, want.busy_res));
          if (got.accepted !== want.accepted)
            report_mismatch($sformatf("word %0d accepted got %b expected %b",
                                      word_count, got.accepted, want.accepted));
          if (got.frame_done !== want.frame_done)
            report_mismatch($sformatf("word %0d frame_done got %b expected %b",
                                      word_count, got.frame_done, want.frame_done));
          if (want.frame_done) done_count++;
        end
        word_count++;
      end
      // result for a tick word never shows in the cycle it is taken
      if (ticks.valid && ticks.ready)
        expected_pins.push_back(advance_waveform(ticks.start_req, ticks.throttle));
    end
    pending       <= expected_pins.size();
    tx_active     <= in_frame;
    errors        <= err_count;
    words_checked <= word_count;
    frames_done   <= done_count;
  end

endmodule

// ----- bench/tb_dshot_frame_transmitter.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_dshot_frame_transmitter
// Drives tick words and register writes into the DShot transmitter under
// several register settings and idle patterns; the pin checker predicts and
// compares every result word, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_dshot_frame_transmitter;
  import dft_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  localparam int                     LIMIT       = 1_000_000; // cycles
  localparam int                     HOLD_CYCLES = 200;       // long receiver hold-off
  localparam int                     SETTLE      = 4;         // settle margin past the result register
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE   = 2'd3;      // not a register, dropped

  logic clk;
  logic rst;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [REG_W-1:0]       cfg_data;

  dft_tick_if   tick_ch ();
  dft_result_if result_ch ();

  int   errors;
  int   pending;
  logic tx_active;
  int   words_checked;
  int   frames_done;

  // idle knobs, percent of cycles
  int send_pct = 0;
  int recv_pct = 0;
  // long hold-off handshake between stimulus and receiver
  int hold_req    = 0;
  int hold_served = 0;
  int settings_used = 0;
  int cycles;

  dshot_frame_transmitter dut (
    .clk       (clk),
    .rst       (rst),
    .ticks     (tick_ch.sink),
    .results   (result_ch.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  dshot_waveform_checker pin_check (
    .clk           (clk),
    .rst           (rst),
    .ticks         (tick_ch.mon),
    .results       (result_ch.mon),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .errors        (errors),
    .pending       (pending),
    .tx_active     (tx_active),
    .words_checked (words_checked),
    .frames_done   (frames_done)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: whole run bounded in cycles.
  initial begin
    cycles = 0;
    while (cycles < LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d result words still due", cycles, pending);
    $display("TEST FAILED");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request so the
  // two-entry queue fills and ticks.ready drops while words keep coming.
  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_served != hold_req) begin
        hold_served++;
        repeat (HOLD_CYCLES) begin
          result_ch.ready <= 1'b0;
          @(posedge clk);
        end
      end
      result_ch.ready <= ($urandom_range(99) >= recv_pct);
    end
  end

  // Throttle picks lean on the edges: zero, all ones, and the band where
  // the doubled value sits around the low threshold.
  function automatic logic [THROTTLE_W-1:0] pick_throttle();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return THROTTLE_W'($urandom_range(LOW_THRESH - 1));
      3:       return THROTTLE_W'(LOW_THRESH / 2 - 1 + $urandom_range(1));
      default: return THROTTLE_W'($urandom);
    endcase
  endfunction

  task automatic set_idle(input idle_mode_t mode);
    case (mode)
      IDLE_NONE: begin send_pct = 0;  recv_pct = 0;  end
      IDLE_SEND: begin send_pct = 51; recv_pct = 0;  end
      IDLE_RECV: begin send_pct = 0;  recv_pct = 51; end
      IDLE_BOTH: begin send_pct = 22; recv_pct = 22; end
      default: ;
    endcase
  endtask

  // Offer one tick word and return at the edge that takes it. valid stays
  // high on return so back-to-back words need no extra assignment.
  task automatic send_word(input logic start, input logic [THROTTLE_W-1:0] thr);
    while ($urandom_range(99) < send_pct) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    tick_ch.valid     <= 1'b1;
    tick_ch.start_req <= start;
    tick_ch.throttle  <= thr;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
  endtask

  // Feed plain ticks until the frame in flight ends, then let every result
  // word drain so the block is idle for a register write.
  task automatic drain_frame();
    tick_ch.valid <= 1'b0;
    @(posedge clk);
    while (tx_active) send_word(1'b0, pick_throttle());
    if (tick_ch.valid) begin
      tick_ch.valid <= 1'b0;
      @(posedge clk);
    end
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [REG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic write_settings(input logic [REG_W-1:0] period, input logic [REG_W-1:0] one_hi,
                                input logic [REG_W-1:0] zero_hi, input bit poke_spare);
    put_reg(REG_BIT_TICKS, period);
    put_reg(REG_ONE_HIGH,  one_hi);
    put_reg(REG_ZERO_HIGH, zero_hi);
    if (poke_spare) put_reg(REG_SPARE, {REG_W{1'b1}});
    cfg_we <= 1'b0;
    @(posedge clk);
    settings_used++;
  endtask

  // Random phase: starts come often enough that frames follow each other
  // closely; starts landing mid-frame are dropped by the block.
  task automatic run_phase(input logic [REG_W-1:0] period, input logic [REG_W-1:0] one_hi,
                           input logic [REG_W-1:0] zero_hi, input idle_mode_t mode,
                           input int n_words, input bit squeeze);
    write_settings(period, one_hi, zero_hi, 1'b0);
    set_idle(mode);
    if (squeeze) hold_req++;
    repeat (n_words) send_word($urandom_range(3) == 0, pick_throttle());
    drain_frame();
  endtask

  initial begin
    rst               = 1'b1;
    tick_ch.valid     = 1'b0;
    tick_ch.start_req = 1'b0;
    tick_ch.throttle  = '0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset register values, no idling.
    set_idle(IDLE_NONE);
    settings_used++;
    repeat (80) send_word($urandom_range(3) == 0, pick_throttle());
    drain_frame();

    // Directed: one-tick bit periods so the line follows the frame bits.
    // Zero throttle (low flag set), then starts during the frame, the last
    // of them on the frame_done tick, then threshold and full-scale values.
    write_settings(12'd1, 12'd1, 12'd0, 1'b1);
    set_idle(IDLE_NONE);
    send_word(1'b1, '0);
    for (int i = 0; i < FRAME_BITS - 1; i++)
      send_word(1'b1, i[0] ? '1 : THROTTLE_W'(1) << (THROTTLE_W - 1));
    send_word(1'b1, THROTTLE_W'(LOW_THRESH / 2));
    drain_frame();
    send_word(1'b1, THROTTLE_W'(LOW_THRESH / 2 - 1));
    drain_frame();
    send_word(1'b1, '1);
    drain_frame();

    // Random phases across the register range and idle patterns.
    run_phase(12'd0,    12'd0,    12'd4095, IDLE_SEND, 120, 1'b0); // zero period, one tick per bit, line inverted
    run_phase(12'd2,    12'd1,    12'd2,    IDLE_RECV, 160, 1'b0);
    run_phase(12'd5,    12'd3,    12'd1,    IDLE_BOTH, 160, 1'b0);
    run_phase(12'd8,    12'd6,    12'd3,    IDLE_NONE, 160, 1'b1); // long receiver hold-off
    run_phase(12'd3,    12'd4095, 12'd1,    IDLE_SEND, 120, 1'b0); // high count past period
    run_phase(12'd1,    12'd2,    12'd0,    IDLE_RECV, 120, 1'b0);
    run_phase(12'd34,   12'd26,   12'd13,   IDLE_BOTH, 100, 1'b0);

    while (pending != 0) @(posedge clk);
    repeat (2 * SETTLE) @(posedge clk);

    $display("Checked %0d tick words over %0d register settings; %0d frames ran to the end.",
             words_checked, settings_used, frames_done);
    $display("Bit periods from one tick to 34 ticks, high counts from zero to beyond the period.");
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d result words missing", errors, pending);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+src
src/dft_pkg.sv
src/dft_interfaces.sv
src/dft_front.sv
src/dft_queue.sv
src/dft_back.sv
src/dshot_frame_transmitter.sv
src/dft_checker.sv
bench/dshot_waveform_checker.sv
bench/tb_dshot_frame_transmitter.sv
